// ===== design/spint_pkg.sv =====
package spint_pkg;

  // Port field widths
  localparam int MODE_W     = 3;
  localparam int IDX_W      = 5;
  localparam int POS_W      = 10;
  localparam int ID_W       = 8;
  localparam int DUR_W      = 16;
  localparam int FL_W       = 10;
  localparam int SC_W       = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // Shared divider: duration / frame length and distance / frames
  localparam int DIVIDEND_W = 16;
  localparam int DIVISOR_W  = 17;

  // Reset values
  localparam int RESET_POS  = 512;
  localparam logic [FL_W-1:0] FL_RESET = FL_W'(33);
  localparam logic [SC_W-1:0] SC_RESET = SC_W'(18);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD_TARGET  = 3'd0,
    MODE_LOAD_CURRENT = 3'd1,
    MODE_SET_ID       = 3'd2,
    MODE_START        = 3'd3,
    MODE_TICK         = 3'd4
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LEN   = 1'd0,
    REG_SERVO_COUNT = 1'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIELD_WR,
    S_FRAMES,
    S_STEP_RD,
    S_STEP_DAT,
    S_STEP_DIV,
    S_TICK_UPD,
    S_TICK_EMIT
  } state_e;

endpackage

// ===== design/spint_ram.sv =====
module spint_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/spint_div.sv =====
module spint_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [spint_pkg::DIVIDEND_W-1:0] dividend_i,
  input  logic [spint_pkg::DIVISOR_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [spint_pkg::DIVIDEND_W-1:0] quotient_o
);

  import spint_pkg::*;

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  den_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  // Restoring division, one quotient bit per cycle, MSB first
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= DIVISOR_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[DIVISOR_W-1:0];
      end
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== design/servo_pose_interpolator.sv =====
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+----------------------------------------
// command   | in        | start & !busy             | mode_i, servo_index_i, position_i,
//           |           |                           | servo_id_i, duration_ms_i
// result    | out       | result_valid_o, 1 cycle   | out_servo_id_o, goal_position_o, idle_o,
//           |           |                           | finished_o, last_of_frame_o
// config    | in        | cfg_valid_i & cfg_ready_o | cfg_index_i, cfg_data_i
//
// Load target / load current / set id: read the entry, then merge and write it back.
// Start: the 16-step shared divider does one divide for the frame count, then one per
// servo entry in use.
// Tick: an update pass and an emit pass over the entry RAM, one entry per cycle.
// Idle or empty ticks make no pass and give a single result.
// After reset the block takes commands at once; unwritten entries read their reset
// value via per-entry valid flops. Results cannot be stalled.
module servo_pose_interpolator #(
  parameter int NUM_SERVOS = 32,
  parameter int FRAC_BITS  = 3
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [spint_pkg::MODE_W-1:0]     mode_i,
  input  logic [spint_pkg::IDX_W-1:0]      servo_index_i,
  input  logic [spint_pkg::POS_W-1:0]      position_i,
  input  logic [spint_pkg::ID_W-1:0]       servo_id_i,
  input  logic [spint_pkg::DUR_W-1:0]      duration_ms_i,
  output logic                             result_valid_o,
  output logic [spint_pkg::ID_W-1:0]       out_servo_id_o,
  output logic [spint_pkg::POS_W-1:0]      goal_position_o,
  output logic                             idle_o,
  output logic                             finished_o,
  output logic                             last_of_frame_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [spint_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [spint_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  import spint_pkg::*;

  localparam int POSE_W = POS_W + FRAC_BITS;
  localparam int STEP_W = POSE_W + 1;
  localparam int AW     = (NUM_SERVOS > 1) ? $clog2(NUM_SERVOS) : 1;
  localparam int CNT_W  = $clog2(NUM_SERVOS + 1);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [STEP_W-1:0] step;
    logic [POSE_W-1:0] tgt;
    logic [POSE_W-1:0] cur;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);
  localparam logic [POSE_W-1:0] POSE_RESET = POSE_W'(RESET_POS) << FRAC_BITS;

  function automatic entry_t reset_entry(input logic [AW-1:0] addr);
    entry_t e;
    e.id   = ID_W'(addr) + ID_W'(1);
    e.step = '0;
    e.tgt  = POSE_RESET;
    e.cur  = POSE_RESET;
    return e;
  endfunction

  // Control and configuration state
  state_e              state_q, state_d;
  logic                moving_q, moving_d;
  logic [FL_W-1:0]     fl_q;
  logic [SC_W-1:0]     sc_q;
  logic [CNT_W-1:0]    ptr_q, ptr_d;
  logic                all_arr_q, all_arr_d;
  logic [NUM_SERVOS-1:0] vld_q;
  logic                rd_pend_q;
  logic                rd_vld_q;
  logic [AW-1:0]       rd_addr_q;

  // Latched command fields and work registers
  mode_e               mode_q, mode_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [ID_W-1:0]     id_q, id_d;
  logic [DIVISOR_W-1:0] frames_q, frames_d;
  entry_t              ent_q, ent_d;

  // Result register
  logic                res_vld_q, res_vld_d;
  logic [ID_W-1:0]     res_id_q, res_id_d;
  logic [POS_W-1:0]    res_pos_q, res_pos_d;
  logic                res_idle_q, res_idle_d;
  logic                res_fin_q, res_fin_d;
  logic                res_last_q, res_last_d;

  // RAM and divider hookup
  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  entry_t              ram_wdata;
  logic [ENT_W-1:0]    ram_rdata;
  logic                div_start, div_done;
  logic [DIVIDEND_W-1:0] div_dividend, div_quotient;
  logic [DIVISOR_W-1:0]  div_divisor;

  logic                accept;
  logic [6:0]          cnt7;
  logic                idx_ok;
  logic                ptr_more;
  logic                last_rd;
  logic [FL_W-1:0]     fl_eff;
  entry_t              rd_ent;
  entry_t              upd_ent;
  logic                up;
  logic [POSE_W-1:0]   span;
  logic                arrived;
  logic                frame_fin;

  assign accept      = start && (state_q == S_IDLE);
  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Servos in use: servo_count capped at the table depth
  assign cnt7     = ({1'b0, sc_q} < 7'(NUM_SERVOS)) ? {1'b0, sc_q} : 7'(NUM_SERVOS);
  assign idx_ok   = {2'b00, servo_index_i} < cnt7;
  assign ptr_more = 7'(ptr_q) < cnt7;
  assign last_rd  = (7'(rd_addr_q) + 7'd1) == cnt7;
  assign fl_eff   = (fl_q == '0) ? FL_W'(1) : fl_q;

  // Entries never written read back as their reset value
  assign rd_ent = rd_vld_q ? entry_t'(ram_rdata) : reset_entry(rd_addr_q);

  // One frame step of the entry just read, with snap to target
  assign up        = rd_ent.tgt > rd_ent.cur;
  assign span      = up ? (rd_ent.tgt - rd_ent.cur) : (rd_ent.cur - rd_ent.tgt);
  assign arrived   = (rd_ent.cur == rd_ent.tgt) || (STEP_W'(span) < rd_ent.step);
  assign frame_fin = all_arr_q && arrived;

  always_comb begin
    upd_ent = rd_ent;
    if (arrived) begin
      upd_ent.cur = rd_ent.tgt;
    end else if (up) begin
      upd_ent.cur = rd_ent.cur + POSE_W'(rd_ent.step);
    end else begin
      upd_ent.cur = rd_ent.cur - POSE_W'(rd_ent.step);
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (mode_e'(mode_i))
            MODE_LOAD_TARGET, MODE_LOAD_CURRENT, MODE_SET_ID: begin
              if (idx_ok) state_d = S_FIELD_WR;
            end
            MODE_START: state_d = S_FRAMES;
            MODE_TICK: begin
              if (moving_q && (cnt7 != 7'd0)) state_d = S_TICK_UPD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_FIELD_WR: state_d = S_IDLE;
      S_FRAMES: begin
        if (div_done) state_d = (cnt7 == 7'd0) ? S_IDLE : S_STEP_RD;
      end
      S_STEP_RD:  state_d = S_STEP_DAT;
      S_STEP_DAT: state_d = S_STEP_DIV;
      S_STEP_DIV: begin
        if (div_done) state_d = last_rd ? S_IDLE : S_STEP_RD;
      end
      S_TICK_UPD: begin
        if (!ptr_more && rd_pend_q) state_d = S_TICK_EMIT;
      end
      S_TICK_EMIT: begin
        if (!ptr_more && rd_pend_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    moving_d     = moving_q;
    ptr_d        = ptr_q;
    all_arr_d    = all_arr_q;
    mode_d       = mode_q;
    pos_d        = pos_q;
    id_d         = id_q;
    frames_d     = frames_q;
    ent_d        = ent_q;
    ram_we       = 1'b0;
    ram_waddr    = rd_addr_q;
    ram_wdata    = upd_ent;
    ram_re       = 1'b0;
    ram_raddr    = ptr_q[AW-1:0];
    div_start    = 1'b0;
    div_dividend = DIVIDEND_W'(span);
    div_divisor  = frames_q;
    res_vld_d    = 1'b0;
    res_id_d     = '0;
    res_pos_d    = '0;
    res_idle_d   = 1'b0;
    res_fin_d    = 1'b0;
    res_last_d   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          mode_d = mode_e'(mode_i);
          pos_d  = position_i;
          id_d   = servo_id_i;
          case (mode_e'(mode_i))
            MODE_LOAD_TARGET, MODE_LOAD_CURRENT, MODE_SET_ID: begin
              ram_re    = idx_ok;
              ram_raddr = AW'(servo_index_i);
            end
            MODE_START: begin
              moving_d     = 1'b1;
              div_start    = 1'b1;
              div_dividend = duration_ms_i;
              div_divisor  = DIVISOR_W'(fl_eff);
            end
            MODE_TICK: begin
              ptr_d     = '0;
              all_arr_d = 1'b1;
              if (!moving_q) begin
                res_vld_d  = 1'b1;
                res_idle_d = 1'b1;
                res_last_d = 1'b1;
              end else if (cnt7 == 7'd0) begin
                // empty table ends the move at once
                moving_d   = 1'b0;
                res_vld_d  = 1'b1;
                res_fin_d  = 1'b1;
                res_last_d = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_FIELD_WR: begin
        ram_we    = 1'b1;
        ram_wdata = rd_ent;
        case (mode_q)
          MODE_LOAD_TARGET:  ram_wdata.tgt = POSE_W'(pos_q) << FRAC_BITS;
          MODE_LOAD_CURRENT: ram_wdata.cur = POSE_W'(pos_q) << FRAC_BITS;
          MODE_SET_ID:       ram_wdata.id  = id_q;
          default: ;
        endcase
      end
      S_FRAMES: begin
        ptr_d = '0;
        if (div_done) begin
          frames_d = DIVISOR_W'(div_quotient) + DIVISOR_W'(1);
        end
      end
      S_STEP_RD: begin
        ram_re = 1'b1;
      end
      S_STEP_DAT: begin
        ent_d     = rd_ent;
        div_start = 1'b1;
      end
      S_STEP_DIV: begin
        ram_wdata      = ent_q;
        ram_wdata.step = STEP_W'(div_quotient) + STEP_W'(1);
        if (div_done) begin
          ram_we = 1'b1;
          ptr_d  = ptr_q + CNT_W'(1);
        end
      end
      S_TICK_UPD: begin
        if (ptr_more) begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + CNT_W'(1);
        end
        if (rd_pend_q) begin
          ram_we    = 1'b1;
          all_arr_d = frame_fin;
          if (!ptr_more) begin
            ptr_d    = '0;
            moving_d = !frame_fin;
          end
        end
      end
      S_TICK_EMIT: begin
        if (ptr_more) begin
          ram_re = 1'b1;
          ptr_d  = ptr_q + CNT_W'(1);
        end
        if (rd_pend_q) begin
          res_vld_d  = 1'b1;
          res_id_d   = rd_ent.id;
          res_pos_d  = rd_ent.cur[POSE_W-1:FRAC_BITS];
          res_fin_d  = all_arr_q;
          res_last_d = last_rd;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      moving_q   <= 1'b0;
      fl_q       <= FL_RESET;
      sc_q       <= SC_RESET;
      ptr_q      <= '0;
      all_arr_q  <= 1'b0;
      vld_q      <= '0;
      rd_pend_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      rd_addr_q  <= '0;
      res_vld_q  <= 1'b0;
      res_id_q   <= '0;
      res_pos_q  <= '0;
      res_idle_q <= 1'b0;
      res_fin_q  <= 1'b0;
      res_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      moving_q   <= moving_d;
      ptr_q      <= ptr_d;
      all_arr_q  <= all_arr_d;
      rd_pend_q  <= ram_re;
      res_vld_q  <= res_vld_d;
      res_id_q   <= res_id_d;
      res_pos_q  <= res_pos_d;
      res_idle_q <= res_idle_d;
      res_fin_q  <= res_fin_d;
      res_last_q <= res_last_d;
      if (ram_re) begin
        rd_addr_q <= ram_raddr;
        rd_vld_q  <= vld_q[ram_raddr];
      end
      if (ram_we) begin
        vld_q[ram_waddr] <= 1'b1;
      end
      if (cfg_valid_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_FRAME_LEN:   fl_q <= cfg_data_i[FL_W-1:0];
          REG_SERVO_COUNT: sc_q <= cfg_data_i[SC_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    pos_q    <= pos_d;
    id_q     <= id_d;
    frames_q <= frames_d;
    ent_q    <= ent_d;
  end

  spint_ram #(
    .WIDTH (ENT_W),
    .DEPTH (NUM_SERVOS)
  ) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  spint_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  assign result_valid_o  = res_vld_q;
  assign out_servo_id_o  = res_id_q;
  assign goal_position_o = res_pos_q;
  assign idle_o          = res_idle_q;
  assign finished_o      = res_fin_q;
  assign last_of_frame_o = res_last_q;

endmodule
